// File: hdl/vks_pkg.sv
package vks_pkg;

	// number of CORDIC micro-rotations, one cell each (8..30)
	localparam int CordicIters = 16;

	localparam int IdxW = 5;
	localparam int CW   = 34;   // CORDIC x/y/z width, Q2.30 plus headroom
	localparam int DW   = 49;   // travel distance width, Q16.32

	localparam logic [31:0]   TurnPerRad = 32'd683565276;
	localparam logic signed [CW-1:0] CordicX0 = 34'sd652032874;

	localparam logic [7:0] REG_DT        = 8'd0;
	localparam logic [7:0] REG_SPEED_LIM = 8'd1;
	localparam logic [7:0] REG_TURN_MIN  = 8'd2;
	localparam logic [7:0] REG_TURN_MAX  = 8'd3;

	// arctangent of 2^-i in binary angle units (2^32 = one turn)
	localparam logic [29:0] ATAN_TURNS [32] = '{
		30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
		30'd42667331, 30'd21354465, 30'd10679838, 30'd5340245,
		30'd2670163, 30'd1335087, 30'd667544, 30'd333772,
		30'd166886, 30'd83443, 30'd41722, 30'd20861,
		30'd10430, 30'd5215, 30'd2608, 30'd1304,
		30'd652, 30'd326, 30'd163, 30'd81,
		30'd41, 30'd20, 30'd10, 30'd5,
		30'd3, 30'd1, 30'd0, 30'd0
	};

	// side data that rides along the rotation chain
	typedef struct packed {
		logic signed [31:0]   px;
		logic signed [31:0]   py;
		logic signed [DW-1:0] travel;
		logic [30:0]          nv;
		logic signed [31:0]   nth;
		logic                 flip;
	} vks_carry_t;

	function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
		logic signed [31:0] r;
		if (v > 68'sd2147483647) r = 32'sh7FFF_FFFF;
		else if (v < -68'sd2147483648) r = 32'sh8000_0000;
		else r = v[31:0];
		return r;
	endfunction

endpackage

// File: hdl/vks_cell.sv
module vks_cell (
	input  logic                            clk,
	input  logic                            en,
	input  logic [vks_pkg::IdxW-1:0]        idx,
	input  logic signed [vks_pkg::CW-1:0]   x_in,
	input  logic signed [vks_pkg::CW-1:0]   y_in,
	input  logic signed [vks_pkg::CW-1:0]   z_in,
	input  vks_pkg::vks_carry_t             carry_in,
	output logic signed [vks_pkg::CW-1:0]   x_q,
	output logic signed [vks_pkg::CW-1:0]   y_q,
	output logic signed [vks_pkg::CW-1:0]   z_q,
	output vks_pkg::vks_carry_t             carry_q
);

	logic signed [vks_pkg::CW-1:0] xs, ys, at;

	assign xs = x_in >>> idx;
	assign ys = y_in >>> idx;
	assign at = $signed({{(vks_pkg::CW-30){1'b0}}, vks_pkg::ATAN_TURNS[idx]});

	always_ff @(posedge clk) begin
		if (en) begin
			if (!z_in[vks_pkg::CW-1]) begin
				x_q <= x_in - ys;
				y_q <= y_in + xs;
				z_q <= z_in - at;
			end else begin
				x_q <= x_in + ys;
				y_q <= y_in - xs;
				z_q <= z_in + at;
			end
			carry_q <= carry_in;
		end
	end

endmodule

// File: hdl/vks_proj.sv
module vks_proj (
	input  logic                            clk,
	input  logic                            en,
	input  logic signed [vks_pkg::CW-1:0]   x_in,
	input  logic signed [vks_pkg::CW-1:0]   y_in,
	input  vks_pkg::vks_carry_t             carry_in,
	output logic signed [31:0]              next_x_q,
	output logic signed [31:0]              next_y_q,
	output logic [30:0]                     next_speed_q,
	output logic signed [31:0]              next_heading_q
);

	logic signed [vks_pkg::CW:0]   c, s;
	logic signed [32:0]            dhi;
	logic signed [16:0]            dlo;
	logic signed [67:0]            chi_s1, shi_s1;
	logic signed [51:0]            clo_s1, slo_s1;
	vks_pkg::vks_carry_t           carry_s1;
	logic signed [67:0]            sum_x, sum_y, nx, ny;

	assign c   = carry_in.flip ? -(35'(x_in)) : 35'(x_in);
	assign s   = carry_in.flip ? -(35'(y_in)) : 35'(y_in);
	assign dhi = 33'(carry_in.travel >>> 16);
	assign dlo = $signed({1'b0, carry_in.travel[15:0]});

	// split c*d into c*hi and c*lo to keep each multiplier narrow
	always_ff @(posedge clk) begin
		if (en) begin
			chi_s1   <= 68'(c * dhi);
			shi_s1   <= 68'(s * dhi);
			clo_s1   <= 52'(c * dlo);
			slo_s1   <= 52'(s * dlo);
			carry_s1 <= carry_in;
		end
	end

	assign sum_x = chi_s1 + 68'(clo_s1 >>> 16);
	assign sum_y = shi_s1 + 68'(slo_s1 >>> 16);
	assign nx    = 68'(carry_s1.px) + (sum_x >>> 30);
	assign ny    = 68'(carry_s1.py) + (sum_y >>> 30);

	always_ff @(posedge clk) begin
		if (en) begin
			next_x_q       <= vks_pkg::sat32(nx);
			next_y_q       <= vks_pkg::sat32(ny);
			next_speed_q   <= carry_s1.nv;
			next_heading_q <= carry_s1.nth;
		end
	end

endmodule

// File: hdl/vehicle_kinematic_step.sv
// Throughput: one word per cycle; the whole pipeline advances together and
// holds only while a finished word sits in the output register under stall.
// Reset (arst_n low, asynchronous) empties the pipeline and loads the
// register defaults: step 6554 (0.1 s), speed limit 20 m/s, yaw limits +/-1 rad/s.
module vehicle_kinematic_step (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic [30:0]        speed,
	input  logic signed [31:0] heading,
	input  logic signed [31:0] accel,
	input  logic signed [31:0] turn_rate,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] next_x,
	output logic signed [31:0] next_y,
	output logic [30:0]        next_speed,
	output logic signed [31:0] next_heading,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [7:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	localparam int N     = vks_pkg::CordicIters;
	localparam int Depth = N + 5;   // 3 front stages, N cells, 2 projection stages

	// configuration registers
	logic [15:0]        step_q;
	logic [30:0]        vlim_q;
	logic signed [31:0] yaw_min_q, yaw_max_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q    <= 16'd6554;
			vlim_q    <= 31'd1310720;
			yaw_min_q <= -32'sd65536;
			yaw_max_q <= 32'sd65536;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				vks_pkg::REG_DT:        step_q    <= cfg_data[15:0];
				vks_pkg::REG_SPEED_LIM: vlim_q    <= cfg_data[30:0];
				vks_pkg::REG_TURN_MIN:  yaw_min_q <= $signed(cfg_data);
				vks_pkg::REG_TURN_MAX:  yaw_max_q <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// global advance: everything moves unless the output word is stalled
	logic             adv;
	logic [Depth-1:0] valid_q;

	assign adv       = !valid_q[Depth-1] || !out_stall;
	assign in_stall  = !adv;
	assign out_valid = valid_q[Depth-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (adv) begin
			valid_q <= {valid_q[Depth-2:0], in_valid};
		end
	end

	logic signed [16:0] dt_s;
	assign dt_s = $signed({1'b0, step_q});

	// front stage 1: binary angle, quadrant fold, yaw clamp, first products
	logic signed [62:0] ang_prod;
	logic [31:0]        ang, ang_fold, ang_off;
	logic               fold;
	logic signed [31:0] w_lo, w_cl;

	assign ang_prod = heading * $signed({1'b0, vks_pkg::TurnPerRad[30:0]});
	assign ang      = ang_prod[47:16];
	assign ang_off  = ang + 32'h4000_0000;
	assign fold     = ang_off[31];
	assign ang_fold = fold ? ang + 32'h8000_0000 : ang;
	assign w_lo     = (turn_rate < yaw_min_q) ? yaw_min_q : turn_rate;
	assign w_cl     = (w_lo > yaw_max_q) ? yaw_max_q : w_lo;

	logic signed [31:0] px_s1, py_s1, th_s1;
	logic [30:0]        v_s1;
	logic signed [33:0] z_s1;
	logic               flip_s1;
	logic signed [48:0] adt_s1, wdt_s1;
	logic [46:0]        vdt_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			px_s1   <= pos_x;
			py_s1   <= pos_y;
			th_s1   <= heading;
			v_s1    <= speed;
			z_s1    <= 34'($signed(ang_fold));
			flip_s1 <= fold;
			adt_s1  <= 49'(accel * dt_s);
			wdt_s1  <= 49'(w_cl * dt_s);
			vdt_s1  <= 47'(speed * step_q);
		end
	end

	// front stage 2: a*dt*dt/2, speed update and clamp, heading update
	logic signed [65:0] add2;
	logic signed [33:0] nv_raw;
	logic [30:0]        nv_cl;
	logic signed [67:0] nth_raw;

	assign add2    = adt_s1 * dt_s;
	assign nv_raw  = $signed({3'b000, v_s1}) + 34'(adt_s1 >>> 16);
	assign nv_cl   = nv_raw[33] ? 31'd0 :
		(nv_raw > $signed({3'b000, vlim_q})) ? vlim_q : nv_raw[30:0];
	assign nth_raw = 68'(th_s1) + 68'(wdt_s1 >>> 16);

	logic signed [31:0] px_s2, py_s2, nth_s2;
	logic [30:0]        nv_s2;
	logic signed [33:0] z_s2;
	logic               flip_s2;
	logic signed [48:0] half_s2;
	logic [46:0]        vdt_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			px_s2   <= px_s1;
			py_s2   <= py_s1;
			nv_s2   <= nv_cl;
			nth_s2  <= vks_pkg::sat32(nth_raw);
			z_s2    <= z_s1;
			flip_s2 <= flip_s1;
			half_s2 <= 49'(add2 >>> 17);
			vdt_s2  <= vdt_s1;
		end
	end

	// front stage 3: travel distance, seed of the rotation chain
	vks_pkg::vks_carry_t carry_s3;
	logic signed [33:0]  z_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			carry_s3.px     <= px_s2;
			carry_s3.py     <= py_s2;
			carry_s3.nv     <= nv_s2;
			carry_s3.nth    <= nth_s2;
			carry_s3.flip   <= flip_s2;
			carry_s3.travel <= $signed({2'b00, vdt_s2}) + half_s2;
			z_s3            <= z_s2;
		end
	end

	// CORDIC rotation chain: one micro-rotation per cell
	logic signed [33:0]  cx [N+1];
	logic signed [33:0]  cy [N+1];
	logic signed [33:0]  cz [N+1];
	vks_pkg::vks_carry_t cc [N+1];

	assign cx[0] = vks_pkg::CordicX0;
	assign cy[0] = '0;
	assign cz[0] = z_s3;
	assign cc[0] = carry_s3;

	for (genvar i = 0; i < N; i++) begin : g_cell
		vks_cell u_cell (
			.clk      (clk),
			.en       (adv),
			.idx      (vks_pkg::IdxW'(i)),
			.x_in     (cx[i]),
			.y_in     (cy[i]),
			.z_in     (cz[i]),
			.carry_in (cc[i]),
			.x_q      (cx[i+1]),
			.y_q      (cy[i+1]),
			.z_q      (cz[i+1]),
			.carry_q  (cc[i+1])
		);
	end

	// projection of distance onto cos/sin, position add, saturation
	vks_proj u_proj (
		.clk            (clk),
		.en             (adv),
		.x_in           (cx[N]),
		.y_in           (cy[N]),
		.carry_in       (cc[N]),
		.next_x_q       (next_x),
		.next_y_q       (next_y),
		.next_speed_q   (next_speed),
		.next_heading_q (next_heading)
	);

	// final z residue is not needed
	logic unused_z;
	assign unused_z = ^cz[N];

endmodule
